FILE: sv/taylor_sine_cosine_tangent_macros.svh
// Assertion macros shared by the checker of the sine/cosine/tangent unit.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef TAYLOR_SINE_COSINE_TANGENT_MACROS_SVH
`define TAYLOR_SINE_COSINE_TANGENT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TSCT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("implication check failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define TSCT_ASSERT_DLY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
	else $error("delayed check failed");

// Expression must never be true outside reset.
`define TSCT_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("forbidden condition seen");

`endif

FILE: sv/tsct_pkg.sv
// Package of the sine/cosine/tangent unit: widths, codes and stage records.
// No dependencies; used by every module of the block.
package tsct_pkg;

	localparam int FRAC  = 28;
	localparam int TERMS = 9;
	localparam int AW    = 32;
	localparam int OW    = 48;
	localparam int X2W   = 2 * AW - 1 - FRAC;
	localparam int MW    = 63;
	localparam int TW    = 64;
	localparam int QB    = 51;
	localparam int RSH   = 72;
	localparam int RW    = 72;
	localparam int DW    = 9;
	localparam int LAT   = 4 * (TERMS - 1) + QB + 6;

	localparam logic [1:0] FUNC_SIN = 2'd0;
	localparam logic [1:0] FUNC_COS = 2'd1;
	localparam logic [1:0] FUNC_TAN = 2'd2;

	localparam logic signed [TW-1:0] ONE      = 64'sd1 <<< FRAC;
	localparam logic [MW-1:0]        WORK_LIM = {1'b1, 62'd0};
	localparam logic signed [OW-1:0] OUT_MAX  = {1'b0, {(OW-1){1'b1}}};
	localparam logic signed [OW-1:0] OUT_MIN  = {1'b1, {(OW-1){1'b0}}};

	typedef struct packed {
		logic [1:0]              func;
		logic signed [AW-1:0]    x;
	} side_t;

	typedef struct packed {
		side_t                   side;
		logic [X2W-1:0]          x2;
		logic signed [TW-1:0]    t;
		logic                    flag;
	} hor_t;

	typedef struct packed {
		side_t                   side;
		logic [MW-1:0]           rem;
		logic [QB-1:0]           num;
		logic [QB-1:0]           q;
		logic [MW-1:0]           uc;
		logic                    neg;
		logic                    s_neg;
		logic                    zero;
		logic                    qsat;
		logic                    flag;
		logic signed [TW-1:0]    v;
	} div_t;

endpackage

FILE: sv/tsct_hcell.sv
// One Horner level of the series: T' = 1 - round(round(x2*T)/d).
// Depends on tsct_pkg; four register stages, one level per cell.
module tsct_hcell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [tsct_pkg::DW-1:0]  d,
	input  logic [tsct_pkg::RW-1:0]  recip,
	input  logic                     vin,
	input  tsct_pkg::hor_t           din,
	output logic                     vout,
	output tsct_pkg::hor_t           dout
);
	import tsct_pkg::*;

	localparam int PW = X2W + 32;
	localparam int SW = X2W + MW + 1;
	localparam int NW = MW + 24;
	localparam int QW = NW + 49;

	logic [TW-1:0]    tabs;
	logic [MW-1:0]    mt;
	logic             v_s1, v_s2, v_s3;
	hor_t             h_s1, h_s2, h_s3;
	logic             neg_s1, neg_s2, neg_s3;
	logic [PW-1:0]    pl_s1;
	logic [PW-2:0]    ph_s1;
	logic [SW-1:0]    prod, m;
	logic             sat;
	logic [MW-1:0]    mag, nsum;
	hor_t             hsat;
	logic [MW-1:0]    n_s2;
	logic [NW-1:0]    r0_s3, r1_s3, r2_s3;
	logic [QW-1:0]    qsum;
	logic signed [TW-1:0] qv, tdiv;
	hor_t             nxt;

	always_comb begin
		tabs = din.t[TW-1] ? TW'(-din.t) : TW'(din.t);
		mt   = tabs[MW-1:0];
	end

	// rounded square-by-T product, saturated to the work limit
	always_comb begin
		prod = SW'(pl_s1) + (SW'(ph_s1) << 32) + (SW'(1) << (FRAC - 1));
		m    = prod >> FRAC;
		sat  = m > SW'(WORK_LIM);
		mag  = sat ? WORK_LIM : m[MW-1:0];
		nsum = mag + MW'(d >> 1);
		hsat = h_s1;
		hsat.flag = h_s1.flag | sat;
	end

	// exact quotient by reciprocal: ceil(2^RSH/d), no correction needed
	always_comb begin
		qsum = QW'(r0_s3) + (QW'(r1_s3) << 24) + (QW'(r2_s3) << 48);
		qv   = TW'(qsum[RSH+MW-1:RSH]);
		tdiv = neg_s3 ? -qv : qv;
		nxt  = h_s3;
		nxt.t = ONE - tdiv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vout <= 1'b0;
		end else begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vout <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		h_s1   <= din;
		neg_s1 <= din.t[TW-1];
		pl_s1  <= PW'(din.x2) * PW'(mt[31:0]);
		ph_s1  <= (PW-1)'(din.x2) * (PW-1)'(mt[MW-1:32]);
		h_s2      <= hsat;
		neg_s2    <= neg_s1;
		n_s2      <= nsum;
		h_s3   <= h_s2;
		neg_s3 <= neg_s2;
		r0_s3  <= NW'(n_s2) * NW'(recip[23:0]);
		r1_s3  <= NW'(n_s2) * NW'(recip[47:24]);
		r2_s3  <= NW'(n_s2) * NW'(recip[71:48]);
		dout   <= nxt;
	end

endmodule

FILE: sv/tsct_dcell.sv
// One quotient bit of the tangent divider: shift in a dividend bit, compare, subtract.
// Depends on tsct_pkg; one register stage per cell.
module tsct_dcell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vin,
	input  tsct_pkg::div_t  din,
	output logic            vout,
	output tsct_pkg::div_t  dout
);
	import tsct_pkg::*;

	logic [MW:0] r2, rn;
	logic        ge;
	div_t        nxt;

	always_comb begin
		r2  = {din.rem, din.num[QB-1]};
		ge  = r2 >= {1'b0, din.uc};
		rn  = ge ? r2 - {1'b0, din.uc} : r2;
		nxt = din;
		nxt.rem = rn[MW-1:0];
		nxt.num = din.num << 1;
		nxt.q   = {din.q[QB-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

FILE: sv/taylor_sine_cosine_tangent.sv
// Top level of the Taylor-series sine/cosine/tangent unit.
// Depends on tsct_pkg, tsct_hcell and tsct_dcell.
//
// Usage:
//   Input channel: drive func (0 sine, 1 cosine, 2 or 3 tangent) and angle
//   (signed Q4.28 radians) with start high; a transaction is taken at each
//   edge where start is high and busy is low. busy is always low, so one
//   angle can be issued every cycle.
//   Result channel: done is high for exactly one cycle with value (signed
//   Q20.28) and overflow. Results leave in issue order.
//   Pipeline stages: two for the square, four per Horner cell in the
//   sine and cosine rows, two for the final product, one setup, one per
//   quotient bit of the 51-cell divider row, one for rounding and
//   clamping. Every function takes the same path length, so throughput
//   is one transaction per cycle.
//   The receiver cannot stall; done is a pure strobe.
//   Reset clears only the valid bits of the pipeline; transactions in flight
//   are dropped.
module taylor_sine_cosine_tangent (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      func,
	input  logic signed [tsct_pkg::AW-1:0]  angle,
	output logic                            done,
	output logic signed [tsct_pkg::OW-1:0]  value,
	output logic                            overflow
);
	import tsct_pkg::*;

	localparam int FW = 2 * AW + MW - 31;

	logic                    v_s1, v_s2;
	side_t                   side_s1;
	logic signed [2*AW-1:0]  sq_s1;
	logic [2*AW-1:0]         sqr;
	hor_t                    hsq;
	hor_t                    hin_s2;

	hor_t                    sin_h [TERMS];
	hor_t                    cos_h [TERMS];
	logic                    sin_v [TERMS];
	logic                    cos_v [TERMS];

	hor_t                    hs, hc;
	logic [AW-1:0]           mx;
	logic [TW-1:0]           tsa;
	logic                    v_s3, v_s4, v_s5;
	side_t                   side_s3, side_s4;
	logic [2*AW-1:0]         pml_s3;
	logic [2*AW-2:0]         pmh_s3;
	logic                    neg_s3;
	logic                    fs_s3, fc_s3, fs_s4, fc_s4;
	logic signed [TW-1:0]    c_s3, c_s4, s_s4;
	logic [FW-1:0]           fprod, fm;
	logic                    fsat;
	logic [MW-1:0]           fmag;
	logic signed [TW-1:0]    sval;

	logic [TW-1:0]           usa, uca;
	logic [MW-1:0]           us, uc, hi0;
	div_t                    dprep;
	div_t                    dv [QB+1];
	logic                    dvv [QB+1];

	div_t                    df;
	logic                    rup;
	logic [QB:0]             qr;
	logic signed [TW-1:0]    tq, tv, vres;
	logic                    fres, isneg;
	logic signed [OW-1:0]    vout;
	logic                    oout;

	assign busy = 1'b0;

	// square and first Horner input
	always_comb begin
		sqr = sq_s1 + ((2*AW)'(1) << (FRAC - 1));
		hsq.side = side_s1;
		hsq.x2   = sqr[FRAC+X2W-1:FRAC];
		hsq.t    = ONE;
		hsq.flag = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.func <= func;
		side_s1.x    <= angle;
		sq_s1        <= angle * angle;
		hin_s2       <= hsq;
	end

	assign sin_h[0] = hin_s2;
	assign cos_h[0] = hin_s2;
	assign sin_v[0] = v_s2;
	assign cos_v[0] = v_s2;

	// level n = TERMS-1 comes first and level 1 last
	for (genvar i = 0; i < TERMS - 1; i++) begin : g_row
		localparam int          N   = TERMS - 1 - i;
		localparam logic [79:0] DS  = 80'(2 * N * (2 * N + 1));
		localparam logic [79:0] DC  = 80'((2 * N - 1) * (2 * N));
		localparam logic [79:0] RS  = ((80'd1 << RSH) + DS - 80'd1) / DS;
		localparam logic [79:0] RC  = ((80'd1 << RSH) + DC - 80'd1) / DC;

		tsct_hcell u_sin (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (DS[DW-1:0]),
			.recip  (RS[RW-1:0]),
			.vin    (sin_v[i]),
			.din    (sin_h[i]),
			.vout   (sin_v[i+1]),
			.dout   (sin_h[i+1])
		);

		tsct_hcell u_cos (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (DC[DW-1:0]),
			.recip  (RC[RW-1:0]),
			.vin    (cos_v[i]),
			.din    (cos_h[i]),
			.vout   (cos_v[i+1]),
			.dout   (cos_h[i+1])
		);
	end

	// sine = round(x * T), split product
	always_comb begin
		hs  = sin_h[TERMS-1];
		hc  = cos_h[TERMS-1];
		mx  = hs.side.x[AW-1] ? AW'(-hs.side.x) : AW'(hs.side.x);
		tsa = hs.t[TW-1] ? TW'(-hs.t) : TW'(hs.t);
	end

	always_comb begin
		fprod = FW'(pml_s3) + (FW'(pmh_s3) << 32) + (FW'(1) << (FRAC - 1));
		fm    = fprod >> FRAC;
		fsat  = fm > FW'(WORK_LIM);
		fmag  = fsat ? WORK_LIM : fm[MW-1:0];
		sval  = neg_s3 ? -TW'(fmag) : TW'(fmag);
	end

	// divider setup
	always_comb begin
		usa = s_s4[TW-1] ? TW'(-s_s4) : TW'(s_s4);
		uca = c_s4[TW-1] ? TW'(-c_s4) : TW'(c_s4);
		us  = usa[MW-1:0];
		uc  = uca[MW-1:0];
		hi0 = us >> (QB - FRAC);
		dprep.side  = side_s4;
		dprep.rem   = hi0;
		dprep.num   = {us[QB-FRAC-1:0], {FRAC{1'b0}}};
		dprep.q     = '0;
		dprep.uc    = uc;
		dprep.neg   = s_s4[TW-1] ^ c_s4[TW-1];
		dprep.s_neg = s_s4[TW-1];
		dprep.zero  = c_s4 == '0;
		dprep.qsat  = (c_s4 != '0) && (hi0 >= uc);
		case (side_s4.func)
			FUNC_SIN: begin
				dprep.flag = fs_s4;
				dprep.v    = s_s4;
			end
			FUNC_COS: begin
				dprep.flag = fc_s4;
				dprep.v    = c_s4;
			end
			default: begin
				dprep.flag = fs_s4 | fc_s4;
				dprep.v    = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= sin_v[TERMS-1] & cos_v[TERMS-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= hs.side;
		pml_s3  <= (2*AW)'(mx) * (2*AW)'(tsa[31:0]);
		pmh_s3  <= (2*AW-1)'(mx) * (2*AW-1)'(tsa[MW-1:32]);
		neg_s3  <= hs.side.x[AW-1] ^ hs.t[TW-1];
		fs_s3   <= hs.flag;
		fc_s3   <= hc.flag;
		c_s3    <= hc.t;
		side_s4 <= side_s3;
		s_s4    <= sval;
		fs_s4   <= fs_s3 | fsat;
		fc_s4   <= fc_s3;
		c_s4    <= c_s3;
		dv[0]   <= dprep;
	end

	assign dvv[0] = v_s5;

	for (genvar k = 0; k < QB; k++) begin : g_div
		tsct_dcell u_dcell (
			.clk    (clk),
			.arst_n (arst_n),
			.vin    (dvv[k]),
			.din    (dv[k]),
			.vout   (dvv[k+1]),
			.dout   (dv[k+1])
		);
	end

	// round the quotient, pick the result, clamp to the output range
	always_comb begin
		df  = dv[QB];
		rup = {df.rem, 1'b0} >= {1'b0, df.uc};
		qr  = (QB+1)'(df.q) + (QB+1)'(rup);
		tq  = TW'(qr);
		tv  = df.neg ? -tq : tq;
		case (df.side.func)
			FUNC_SIN, FUNC_COS: begin
				vres  = df.v;
				fres  = df.flag;
				isneg = df.v[TW-1];
			end
			default: begin
				vres  = tv;
				fres  = df.flag | df.zero | df.qsat;
				isneg = df.zero ? df.s_neg : (df.qsat ? df.neg : tv[TW-1]);
			end
		endcase
		if (fres) begin
			vout = isneg ? OUT_MIN : OUT_MAX;
			oout = 1'b1;
		end else if (vres > TW'(OUT_MAX)) begin
			vout = OUT_MAX;
			oout = 1'b1;
		end else if (vres < TW'(OUT_MIN)) begin
			vout = OUT_MIN;
			oout = 1'b1;
		end else begin
			vout = vres[OW-1:0];
			oout = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvv[QB];
		end
	end

	always_ff @(posedge clk) begin
		value    <= vout;
		overflow <= oout;
	end

endmodule

FILE: sv/tsct_chk.sv
// Port-level checker for the sine/cosine/tangent unit, bound to the top level.
// Depends on tsct_pkg and taylor_sine_cosine_tangent_macros.svh.
`include "taylor_sine_cosine_tangent_macros.svh"

module tsct_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic [1:0]                      func,
	input logic signed [tsct_pkg::AW-1:0]  angle,
	input logic                            done,
	input logic signed [tsct_pkg::OW-1:0]  value,
	input logic                            overflow
);
	import tsct_pkg::*;

	`TSCT_ASSERT_NEVER(a_never_busy, busy)
	`TSCT_ASSERT_DLY(a_fixed_latency, start && !busy, LAT, done)
	`TSCT_ASSERT_IMP(a_sat_value, done && overflow, value == OUT_MAX || value == OUT_MIN)
	`TSCT_ASSERT_DLY(a_cos_zero, start && !busy && func == FUNC_COS && angle == '0, LAT,
		value == OW'(ONE) && !overflow)

endmodule

bind taylor_sine_cosine_tangent tsct_chk u_tsct_chk (.*);
